>>> rtl/tcs_pkg.sv
// shared widths, limits and defaults for the thresholded chi-square score block
package tcs_pkg;

  // field widths
  localparam int OBS_W   = 20;
  localparam int HYP_W   = 21;
  localparam int THR_W   = 20;
  localparam int SCORE_W = 24;
  localparam int COUNT_W = 6;
  localparam int SUM_W   = 30;

  // datapath widths: difference, square, Q.4 scaled numerator, step counter
  localparam int DIFF_W = OBS_W;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int NUM_W  = PROD_W + 4;
  localparam int DEN_W  = OBS_W + 1;
  localparam int STEP_W = 6;

  // step counts of the serial multiplier and divider
  localparam int MUL_STEPS = DIFF_W;
  localparam int DIV_STEPS = NUM_W;

  // default number of channels in one set
  localparam int MAX_CHANNELS_DEF = 32;

  // fixed-point constants
  localparam logic [DEN_W-1:0]   ONE_Q4    = DEN_W'(16);
  localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
  localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

endpackage

>>> rtl/thresholded_chi_square_score.sv
// top level: thresholded chi-square score with bit-serial square and divide
//
//  channel  | handshake        | fields
//  ---------+------------------+---------------------------------------------
//  channel  | start / busy     | observed_pe, hypothesis_pe, threshold_pe,
//           |                  | last_channel
//  result   | done (one cycle) | chi2_score, valid_channels,
//           |                  | negative_hypothesis, no_valid_channel
//
// a skipped or negative channel keeps busy high through the check state after its beat;
// a contributing channel runs a check, 20 shift-add square steps, 44 restoring
// divide steps (one quotient bit a cycle) and an accumulate.
// the last channel then passes through the final state and a further 44 divide
// steps (no divide when no channel counted) on the same shared divider; done is
// registered in the final state.
// rst clears the set state and control; the receiver cannot stall, each
// result beat is shown for exactly one cycle.
module thresholded_chi_square_score
  import tcs_pkg::*;
#(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [OBS_W-1:0]   observed_pe,
  input  logic [HYP_W-1:0]   hypothesis_pe,
  input  logic [THR_W-1:0]   threshold_pe,
  input  logic               last_channel,
  output logic               done,
  output logic [SCORE_W-1:0] chi2_score,
  output logic [COUNT_W-1:0] valid_channels,
  output logic               negative_hypothesis,
  output logic               no_valid_channel
);

  localparam logic [COUNT_W-1:0] COUNT_LIMIT =
    COUNT_W'((MAX_CHANNELS < 63) ? MAX_CHANNELS : 63);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_MUL   = 6'b000100,
    S_DIV   = 6'b001000,
    S_ACC   = 6'b010000,
    S_FINAL = 6'b100000
  } state_t;

  state_t state;

  // captured channel
  logic [OBS_W-1:0] obs;
  logic [HYP_W-1:0] hyp;
  logic [THR_W-1:0] thr;
  logic             last;

  // serial datapath
  logic [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0] mult;
  logic [PROD_W-1:0] prod;
  logic [NUM_W-1:0]  num;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  divisor;
  logic [STEP_W-1:0] step;
  logic              fin_div;

  // set state
  logic [SUM_W-1:0]   term_sum;
  logic [COUNT_W-1:0] valid_count;
  logic               negative_seen;

  // channel check logic
  logic [DIFF_W-1:0] hyp_mag;
  logic [DIFF_W-1:0] abs_diff;
  logic [DEN_W-1:0]  den_sum;
  logic [DEN_W-1:0]  den;
  logic [THR_W+1:0]  twice_hyp;
  logic [THR_W+1:0]  thrice_thr;
  logic              skip;

  assign hyp_mag    = hyp[DIFF_W-1:0];
  assign abs_diff   = (obs >= hyp_mag) ? (obs - hyp_mag) : (hyp_mag - obs);
  assign den_sum    = {1'b0, obs} + {1'b0, hyp_mag};
  assign den        = (den_sum < ONE_Q4) ? ONE_Q4 : den_sum;
  assign twice_hyp  = {1'b0, hyp_mag, 1'b0};
  assign thrice_thr = {2'b00, thr} + {1'b0, thr, 1'b0};
  assign skip       = (obs < thr) && (twice_hyp < thrice_thr);

  // shift-add square step
  logic [DIFF_W:0] mul_sum;
  assign mul_sum = {1'b0, prod[PROD_W-1:DIFF_W]} + (mult[0] ? {1'b0, diff} : '0);

  // restoring divide step
  logic [DEN_W:0] trial;
  logic [DEN_W:0] trial_sub;
  logic           q_bit;
  logic [DEN_W-1:0] rem_next;
  assign trial     = {rem, num[NUM_W-1]};
  assign q_bit     = (trial >= {1'b0, divisor});
  assign trial_sub = trial - {1'b0, divisor};
  assign rem_next  = q_bit ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];

  // term and score clamps on the finished quotient
  logic [SUM_W-1:0]   term_clamp;
  logic [SUM_W:0]     sum_wide;
  logic [SUM_W-1:0]   sum_sat;
  logic [SCORE_W-1:0] score_clamp;
  assign term_clamp  = (|num[NUM_W-1:SUM_W]) ? SUM_MAX : num[SUM_W-1:0];
  assign sum_wide    = {1'b0, term_sum} + {1'b0, term_clamp};
  assign sum_sat     = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
  assign score_clamp = (|num[NUM_W-1:SCORE_W]) ? SCORE_MAX : num[SCORE_W-1:0];

  assign busy = (state != S_IDLE);

  // control and set state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      done          <= 1'b0;
      term_sum      <= '0;
      valid_count   <= '0;
      negative_seen <= 1'b0;
      fin_div       <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (hyp[HYP_W-1]) begin
            negative_seen <= 1'b1;
            state         <= last ? S_FINAL : S_IDLE;
          end else if (skip) begin
            state <= last ? S_FINAL : S_IDLE;
          end else begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (step == STEP_W'(MUL_STEPS - 1)) begin
            fin_div <= 1'b0;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          if (step == STEP_W'(DIV_STEPS - 1)) begin
            state <= fin_div ? S_FINAL : S_ACC;
          end
        end
        S_ACC: begin
          term_sum <= sum_sat;
          if (valid_count < COUNT_LIMIT) begin
            valid_count <= valid_count + COUNT_W'(1);
          end
          state <= last ? S_FINAL : S_IDLE;
        end
        S_FINAL: begin
          if (valid_count != '0 && !fin_div) begin
            fin_div <= 1'b1;
            state   <= S_DIV;
          end else begin
            done          <= 1'b1;
            fin_div       <= 1'b0;
            term_sum      <= '0;
            valid_count   <= '0;
            negative_seen <= 1'b0;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload and serial datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          obs  <= observed_pe;
          hyp  <= hypothesis_pe;
          thr  <= threshold_pe;
          last <= last_channel;
        end
      end
      S_CHECK: begin
        diff    <= abs_diff;
        mult    <= abs_diff;
        prod    <= '0;
        divisor <= den;
        step    <= '0;
      end
      S_MUL: begin
        prod <= {mul_sum, prod[DIFF_W-1:1]};
        mult <= mult >> 1;
        if (step == STEP_W'(MUL_STEPS - 1)) begin
          num  <= {mul_sum, prod[DIFF_W-1:1], 4'b0000};
          rem  <= '0;
          step <= '0;
        end else begin
          step <= step + STEP_W'(1);
        end
      end
      S_DIV: begin
        rem  <= rem_next;
        num  <= {num[NUM_W-2:0], q_bit};
        step <= step + STEP_W'(1);
      end
      S_FINAL: begin
        if (valid_count != '0 && !fin_div) begin
          num     <= {{(NUM_W-SUM_W){1'b0}}, term_sum};
          divisor <= {{(DEN_W-COUNT_W){1'b0}}, valid_count};
          rem     <= '0;
          step    <= '0;
        end else begin
          chi2_score          <= (valid_count == '0) ? '0 : score_clamp;
          valid_channels      <= valid_count;
          negative_hypothesis <= negative_seen;
          no_valid_channel    <= (valid_count == '0);
        end
      end
      default: begin
      end
    endcase
  end

  // result beat lasts one cycle
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe held longer than one cycle");

  // empty set reports a zero score and zero count
  a_empty_set: assert property (@(posedge clk) disable iff (rst)
    (done && no_valid_channel) |-> (chi2_score == '0 && valid_channels == '0))
    else $error("empty set reported a nonzero score or count");

  // divider remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (rem < divisor))
    else $error("divider remainder out of range");

  // valid count never passes its limit
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    valid_count <= COUNT_LIMIT) else $error("valid count past its limit");

endmodule
